>>> hdl/black_white_black_run_measure_assert.svh
// Assertion macros shared by the run-measure checker.
`ifndef BLACK_WHITE_BLACK_RUN_MEASURE_ASSERT_SVH
`define BLACK_WHITE_BLACK_RUN_MEASURE_ASSERT_SVH

// Checked only outside reset.
`define BWBRM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("run measure assertion failed");

// Checked at every edge, reset included.
`define BWBRM_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("run measure reset assertion failed");

`endif

>>> hdl/bwbrm_pkg.sv
// Package: types, constants and codes of the run-measure block.
`default_nettype none
package bwbrm_pkg;

   localparam int unsigned DEF_IMAGE_COLS = 256;
   localparam int unsigned DEF_IMAGE_ROWS = 256;

   localparam int unsigned DIM_W      = 9;
   localparam int unsigned CSR_AW     = 3;
   localparam int unsigned CSR_DW     = 32;
   localparam int unsigned CRD_W      = 12;
   localparam int unsigned PROD_W     = 2 * CRD_W;
   localparam int unsigned ACC_W      = PROD_W + 1;
   localparam int unsigned SQ_N_W     = 32;
   localparam int unsigned REM_W      = 20;
   localparam int unsigned LEN_W      = 16;
   localparam int unsigned ITER_W     = 5;
   localparam int unsigned DIV_STEPS  = PROD_W;
   localparam int unsigned SQRT_STEPS = SQ_N_W / 2;
   localparam int unsigned FRAC_SHIFT = 12;
   localparam int unsigned ONE_Q6     = 64;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] pix_col;
      logic [7:0] pix_row;
      logic       pix_value;
      logic [7:0] from_col;
      logic [7:0] from_row;
      logic [7:0] to_col;
      logic [7:0] to_row;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] run_length;
      logic             found;
   } rsp_type;

   typedef enum logic {
      CSR_COLS,
      CSR_ROWS
   } csr_idx_type;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SETUP,
      ST_ADDR,
      ST_TEST,
      ST_SQ_DI,
      ST_SQ_DJ,
      ST_ROOT,
      ST_MIR_X,
      ST_CLIP_Y,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIV,
      ST_SUM,
      ST_DONE
   } ctrl_state_type;

endpackage
`default_nettype wire

>>> hdl/bwbrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bwbrm_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> hdl/bwbrm_alu.sv
// Shared arithmetic unit: combinational multiply, bit-serial divide and square root.
`default_nettype none
module bwbrm_alu (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire bwbrm_pkg::alu_cmd_type             cmd,
   input  wire logic signed [bwbrm_pkg::CRD_W-1:0] mul_a,
   input  wire logic signed [bwbrm_pkg::CRD_W-1:0] mul_b,
   input  wire logic [bwbrm_pkg::SQ_N_W-1:0]       itr_n,
   input  wire logic [bwbrm_pkg::CRD_W-1:0]        itr_d,
   output logic signed [bwbrm_pkg::PROD_W-1:0]     prod,
   output bwbrm_pkg::alu_stat_type                 stat,
   output logic [bwbrm_pkg::PROD_W-1:0]            quot,
   output logic [bwbrm_pkg::REM_W-1:0]             rem
);
   import bwbrm_pkg::*;

   logic [SQ_N_W-1:0] n_ff, n_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0] q_ff, q_in;
   logic [CRD_W-1:0]  d_ff;
   logic [ITER_W-1:0] cnt_ff;
   logic              busy_ff, done_ff, sqrt_ff;

   logic [REM_W+1:0]  rs, trial;
   logic [REM_W+2:0]  diff;
   logic              ge;

   assign prod = mul_a * mul_b;

   always_comb begin
      if (sqrt_ff) begin
         rs    = {rem_ff, n_ff[SQ_N_W-1 -: 2]};
         trial = (REM_W+2)'({q_ff[LEN_W-1:0], 2'b01});
         n_in  = n_ff << 2;
      end else begin
         rs    = {1'b0, rem_ff, n_ff[SQ_N_W-1]};
         trial = (REM_W+2)'(d_ff);
         n_in  = n_ff << 1;
      end
      diff   = {1'b0, rs} - {1'b0, trial};
      ge     = !diff[REM_W+2];
      rem_in = ge ? diff[REM_W-1:0] : rs[REM_W-1:0];
      q_in   = {q_ff[PROD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (cmd.start && cmd.op != ALU_MUL) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start && cmd.op != ALU_MUL) begin
         n_ff    <= itr_n;
         rem_ff  <= '0;
         q_ff    <= '0;
         d_ff    <= itr_d;
         sqrt_ff <= (cmd.op == ALU_SQRT);
         cnt_ff  <= (cmd.op == ALU_SQRT) ? ITER_W'(SQRT_STEPS - 1) : ITER_W'(DIV_STEPS - 1);
      end else if (busy_ff) begin
         n_ff   <= n_in;
         rem_ff <= rem_in;
         q_ff   <= q_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;
   assign rem       = rem_ff;
endmodule
`default_nettype wire

>>> hdl/bwbrm_ctrl.sv
// Sequencer: pixel writes, line walks, mirror clipping and length assembly.
`default_nettype none
module bwbrm_ctrl #(
   parameter int unsigned IMAGE_COLS = bwbrm_pkg::DEF_IMAGE_COLS,
   parameter int unsigned IMAGE_ROWS = bwbrm_pkg::DEF_IMAGE_ROWS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire bwbrm_pkg::req_type                  req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output bwbrm_pkg::rsp_type                       rsp_data,
   input  wire logic [bwbrm_pkg::DIM_W-1:0]         cols_in_use,
   input  wire logic [bwbrm_pkg::DIM_W-1:0]         rows_in_use,
   output logic                                     ram_we,
   output logic [$clog2(IMAGE_COLS*IMAGE_ROWS)-1:0] ram_waddr,
   output logic                                     ram_wdata,
   output logic [$clog2(IMAGE_COLS*IMAGE_ROWS)-1:0] ram_raddr,
   input  wire logic                                ram_rdata,
   output bwbrm_pkg::alu_cmd_type                   alu_cmd,
   output logic signed [bwbrm_pkg::CRD_W-1:0]       mul_a,
   output logic signed [bwbrm_pkg::CRD_W-1:0]       mul_b,
   output logic [bwbrm_pkg::SQ_N_W-1:0]             itr_n,
   output logic [bwbrm_pkg::CRD_W-1:0]              itr_d,
   input  wire logic signed [bwbrm_pkg::PROD_W-1:0] prod,
   input  wire bwbrm_pkg::alu_stat_type             alu_stat,
   input  wire logic [bwbrm_pkg::PROD_W-1:0]        quot,
   input  wire logic [bwbrm_pkg::REM_W-1:0]         rem
);
   import bwbrm_pkg::*;

   localparam int unsigned AW = $clog2(IMAGE_COLS * IMAGE_ROWS);
   localparam logic signed [CRD_W-1:0] C_ONE  = 1;
   localparam logic signed [CRD_W-1:0] C_MONE = -1;

   typedef logic signed [CRD_W-1:0] crd_type;

   ctrl_state_type state_ff, state_in;
   logic    walk_ff, walk_in, mir_ff, mir_in;
   crd_type q_fx_ff, q_fx_in, q_fy_ff, q_fy_in, t_x_ff, t_x_in, t_y_ff, t_y_in;
   crd_type wfx_ff, wfx_in, wfy_ff, wfy_in, wtx_ff, wtx_in, wty_ff, wty_in;
   crd_type x_ff, x_in, y_ff, y_in, dx_ff, dx_in, dy_ff, dy_in, err_ff, err_in;
   crd_type di_ff, di_in, dj_ff, dj_in, num_ff, num_in, den_ff, den_in;
   crd_type ox_ff, ox_in, oy_ff, oy_in;
   logic    steep_ff, steep_in, xs_neg_ff, xs_neg_in, ys_neg_ff, ys_neg_in;
   logic [1:0] st_ff, st_in;
   logic    inb_ff, neg_ff, neg_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, acc_sum;
   logic [LEN_W-1:0] l1_ff, l1_in, len_ff, len_in, res_len_ff, res_len_in;
   logic    res_found_ff, res_found_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   crd_type w_eff, h_eff, col_c, row_c, adx, ady, xstep, ystep, err1, x_nx, qs;
   crd_type sfx, sfy, stx, sty, mx;
   logic    inb_c, free, accept, hit, fin;
   logic [1:0] st_nx;
   logic [PROD_W-1:0] mag;
   logic [LEN_W:0] sum;

   always_comb begin
      if (cols_in_use == '0) w_eff = C_ONE;
      else if (int'(cols_in_use) > IMAGE_COLS) w_eff = crd_type'(IMAGE_COLS);
      else w_eff = crd_type'(cols_in_use);
      if (rows_in_use == '0) h_eff = C_ONE;
      else if (int'(rows_in_use) > IMAGE_ROWS) h_eff = crd_type'(IMAGE_ROWS);
      else h_eff = crd_type'(rows_in_use);
   end

   assign free      = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && free);
   assign accept    = req_valid && !req_stall;

   assign ram_we    = accept && req_data.func == FUNC_WRITE
                      && int'(req_data.pix_col) < IMAGE_COLS
                      && int'(req_data.pix_row) < IMAGE_ROWS;
   assign ram_waddr = AW'(AW'(req_data.pix_row) * AW'(IMAGE_COLS) + AW'(req_data.pix_col));
   assign ram_wdata = req_data.pix_value;

   assign col_c     = steep_ff ? y_ff : x_ff;
   assign row_c     = steep_ff ? x_ff : y_ff;
   assign inb_c     = col_c >= 0 && row_c >= 0 && col_c < w_eff && row_c < h_eff;
   assign ram_raddr = AW'(AW'(unsigned'(row_c)) * AW'(IMAGE_COLS) + AW'(unsigned'(col_c)));

   assign acc_sum = acc_ff + ACC_W'(prod);
   assign mag     = PROD_W'(acc_sum[ACC_W-1] ? -acc_sum : acc_sum);
   assign qs      = crd_type'(neg_ff ? (~quot + 1'b1) : quot);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;   mir_ff <= mir_in;
      q_fx_ff <= q_fx_in;   q_fy_ff <= q_fy_in;
      t_x_ff <= t_x_in;     t_y_ff <= t_y_in;
      wfx_ff <= wfx_in;     wfy_ff <= wfy_in;
      wtx_ff <= wtx_in;     wty_ff <= wty_in;
      x_ff <= x_in;         y_ff <= y_in;
      dx_ff <= dx_in;       dy_ff <= dy_in;       err_ff <= err_in;
      di_ff <= di_in;       dj_ff <= dj_in;
      num_ff <= num_in;     den_ff <= den_in;
      ox_ff <= ox_in;       oy_ff <= oy_in;
      steep_ff <= steep_in; xs_neg_ff <= xs_neg_in; ys_neg_ff <= ys_neg_in;
      st_ff <= st_in;       inb_ff <= inb_c;      neg_ff <= neg_in;
      acc_ff <= acc_in;     l1_ff <= l1_in;       len_ff <= len_in;
      res_len_ff <= res_len_in;
      res_found_ff <= res_found_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in = state_ff;
      walk_in = walk_ff;   mir_in = mir_ff;
      q_fx_in = q_fx_ff;   q_fy_in = q_fy_ff;
      t_x_in = t_x_ff;     t_y_in = t_y_ff;
      wfx_in = wfx_ff;     wfy_in = wfy_ff;
      wtx_in = wtx_ff;     wty_in = wty_ff;
      x_in = x_ff;         y_in = y_ff;
      dx_in = dx_ff;       dy_in = dy_ff;       err_in = err_ff;
      di_in = di_ff;       dj_in = dj_ff;
      num_in = num_ff;     den_in = den_ff;
      ox_in = ox_ff;       oy_in = oy_ff;
      steep_in = steep_ff; xs_neg_in = xs_neg_ff; ys_neg_in = ys_neg_ff;
      st_in = st_ff;       neg_in = neg_ff;
      acc_in = acc_ff;     l1_in = l1_ff;       len_in = len_ff;
      res_len_in = res_len_ff;
      res_found_in = res_found_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      alu_cmd.start = 1'b0;
      alu_cmd.op = ALU_MUL;
      mul_a = '0;
      mul_b = '0;
      itr_n = {mag, {(SQ_N_W-PROD_W){1'b0}}};
      itr_d = unsigned'(den_ff);
      adx = '0; ady = '0; sfx = '0; sfy = '0; stx = '0; sty = '0;
      xstep = xs_neg_ff ? C_MONE : C_ONE;
      ystep = ys_neg_ff ? C_MONE : C_ONE;
      err1 = err_ff + dy_ff;
      x_nx = x_ff + xstep;
      hit = 1'b0; fin = 1'b0; st_nx = st_ff;
      mx = '0;
      sum = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.func == FUNC_WRITE) begin
                  rsp_data_in  = '0;
                  rsp_valid_in = 1'b1;
               end else begin
                  q_fx_in  = crd_type'(req_data.from_col);
                  q_fy_in  = crd_type'(req_data.from_row);
                  t_x_in   = crd_type'(req_data.to_col);
                  t_y_in   = crd_type'(req_data.to_row);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            walk_in = 1'b0;
            if (q_fx_ff >= w_eff || q_fy_ff >= h_eff) begin
               res_len_in   = '0;
               res_found_in = 1'b0;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            adx = (q_fx_ff > t_x_ff) ? q_fx_ff - t_x_ff : t_x_ff - q_fx_ff;
            ady = (q_fy_ff > t_y_ff) ? q_fy_ff - t_y_ff : t_y_ff - q_fy_ff;
            steep_in = ady > adx;
            sfx = steep_in ? q_fy_ff : q_fx_ff;
            sfy = steep_in ? q_fx_ff : q_fy_ff;
            stx = steep_in ? t_y_ff : t_x_ff;
            sty = steep_in ? t_x_ff : t_y_ff;
            dx_in = steep_in ? ady : adx;
            dy_in = steep_in ? adx : ady;
            err_in = -(dx_in >>> 1);
            xs_neg_in = !(sfx < stx);
            ys_neg_in = !(sfy < sty);
            wfx_in = sfx; wfy_in = sfy; wtx_in = stx; wty_in = sty;
            x_in = sfx;   y_in = sfy;   st_in = 2'd0;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            state_in = ST_TEST;
         end
         ST_TEST: begin
            hit = (inb_ff && ram_rdata) == (st_ff != 2'd1);
            if (hit && st_ff == 2'd2) begin
               di_in    = x_ff - wfx_ff;
               dj_in    = y_ff - wfy_ff;
               state_in = ST_SQ_DI;
            end else begin
               st_nx = hit ? st_ff + 2'd1 : st_ff;
               st_in = st_nx;
               if (err1 > 0) begin
                  if (y_ff == wty_ff) begin
                     fin = 1'b1;
                  end else begin
                     y_in   = y_ff + ystep;
                     err_in = err1 - dx_ff;
                  end
               end else begin
                  err_in = err1;
               end
               x_in = x_nx;
               if (x_nx == wtx_ff + xstep) fin = 1'b1;
               if (!fin) begin
                  state_in = ST_ADDR;
               end else if (st_nx == 2'd2) begin
                  di_in    = wtx_ff - wfx_ff + xstep;
                  dj_in    = wty_ff - wfy_ff;
                  state_in = ST_SQ_DI;
               end else begin
                  res_len_in   = '0;
                  res_found_in = 1'b0;
                  state_in     = ST_DONE;
               end
            end
         end
         ST_SQ_DI: begin
            mul_a    = di_ff;
            mul_b    = di_ff;
            acc_in   = ACC_W'(prod);
            state_in = ST_SQ_DJ;
         end
         ST_SQ_DJ: begin
            mul_a         = dj_ff;
            mul_b         = dj_ff;
            itr_n         = SQ_N_W'(unsigned'(acc_sum)) << FRAC_SHIFT;
            alu_cmd.start = 1'b1;
            alu_cmd.op    = ALU_SQRT;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            if (alu_stat.done) begin
               len_in = quot[LEN_W-1:0] + LEN_W'(rem > REM_W'(quot[LEN_W-1:0]));
               if (!walk_ff) begin
                  l1_in    = len_in;
                  state_in = ST_MIR_X;
               end else begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_MIR_X: begin
            mx     = (q_fx_ff <<< 1) - t_x_ff;
            num_in = C_ONE;
            den_in = C_ONE;
            ox_in  = mx;
            if (mx < 0) begin
               num_in = q_fx_ff;
               den_in = q_fx_ff - mx;
               ox_in  = '0;
            end else if (mx >= w_eff) begin
               num_in = w_eff - C_ONE - q_fx_ff;
               den_in = mx - q_fx_ff;
               ox_in  = w_eff - C_ONE;
            end
            mir_in   = 1'b0;
            state_in = ST_MUL_A;
         end
         ST_CLIP_Y: begin
            num_in = C_ONE;
            den_in = C_ONE;
            if (oy_ff < 0) begin
               num_in = q_fy_ff;
               den_in = q_fy_ff - oy_ff;
               oy_in  = '0;
            end else if (oy_ff >= h_eff) begin
               num_in = h_eff - C_ONE - q_fy_ff;
               den_in = oy_ff - q_fy_ff;
               oy_in  = h_eff - C_ONE;
            end
            mir_in   = 1'b1;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            mul_a    = mir_ff ? q_fx_ff : q_fy_ff;
            mul_b    = den_ff;
            acc_in   = ACC_W'(prod);
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            mul_a         = mir_ff ? ox_ff - q_fx_ff : q_fy_ff - t_y_ff;
            mul_b         = num_ff;
            neg_in        = acc_sum[ACC_W-1];
            alu_cmd.start = 1'b1;
            alu_cmd.op    = ALU_DIV;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (alu_stat.done) begin
               if (!mir_ff) begin
                  oy_in    = qs;
                  state_in = ST_CLIP_Y;
               end else begin
                  t_x_in   = qs;
                  t_y_in   = oy_ff;
                  walk_in  = 1'b1;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SUM: begin
            sum = {1'b0, l1_ff} + {1'b0, len_ff};
            if (sum < (LEN_W+1)'(ONE_Q6)) begin
               res_len_in = '0;
            end else begin
               sum = sum - (LEN_W+1)'(ONE_Q6);
               res_len_in = sum[LEN_W] ? '1 : sum[LEN_W-1:0];
            end
            res_found_in = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (free) begin
               rsp_data_in.run_length = res_len_ff;
               rsp_data_in.found      = res_found_ff;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
`default_nettype wire

>>> hdl/black_white_black_run_measure.sv
// Top level: register port, image store, sequencer and shared arithmetic unit.
//
//   port   dir  width        what one beat carries
//   req_   in   req_type     pixel write or two-point query
//   rsp_   out  rsp_type     run length (Q10.6) and found flag
//   csr_   i/o  32 data      cols_in_use at 0x0, rows_in_use at 0x4
//
// A pixel write is answered in the cycle after accept. A query walks two lines, n1
// and n2 being the pixels walked on each: each pixel costs one image read and one
// test, and up to two 16-step roots and two 24-step divides run on the one shared
// unit. Reset is synchronous; it sets both registers to 256, and
// image contents stay undefined until written. A result held by rsp_stall
// keeps new beats out.
`default_nettype none
module black_white_black_run_measure #(
   parameter int unsigned IMAGE_COLS = bwbrm_pkg::DEF_IMAGE_COLS,
   parameter int unsigned IMAGE_ROWS = bwbrm_pkg::DEF_IMAGE_ROWS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire bwbrm_pkg::req_type              req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output bwbrm_pkg::rsp_type                   rsp_data,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [bwbrm_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [bwbrm_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [bwbrm_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                                 csr_pready
);
   import bwbrm_pkg::*;

   localparam int unsigned DEPTH = IMAGE_COLS * IMAGE_ROWS;
   localparam int unsigned AW    = $clog2(DEPTH);

   logic [DIM_W-1:0] cols_ff, cols_in, rows_ff, rows_in;
   csr_idx_type      csr_idx;
   logic             csr_wr;

   logic             ram_we, ram_wdata, ram_rdata;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   alu_cmd_type      alu_cmd;
   alu_stat_type     alu_stat;
   logic signed [CRD_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   logic [SQ_N_W-1:0] itr_n;
   logic [CRD_W-1:0]  itr_d;
   logic [PROD_W-1:0] quot;
   logic [REM_W-1:0]  rem;

   assign csr_idx    = csr_idx_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      cols_in    = cols_ff;
      rows_in    = rows_ff;
      csr_prdata = '0;
      unique case (csr_idx)
         CSR_COLS: begin
            csr_prdata = CSR_DW'(cols_ff);
            if (csr_wr) cols_in = csr_pwdata[DIM_W-1:0];
         end
         CSR_ROWS: begin
            csr_prdata = CSR_DW'(rows_ff);
            if (csr_wr) rows_in = csr_pwdata[DIM_W-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= DIM_W'(256);
         rows_ff <= DIM_W'(256);
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   bwbrm_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_image (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bwbrm_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .itr_n (itr_n),
      .itr_d (itr_d),
      .prod  (prod),
      .stat  (alu_stat),
      .quot  (quot),
      .rem   (rem)
   );

   bwbrm_ctrl #(
      .IMAGE_COLS (IMAGE_COLS),
      .IMAGE_ROWS (IMAGE_ROWS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .cols_in_use (cols_ff),
      .rows_in_use (rows_ff),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata),
      .alu_cmd     (alu_cmd),
      .mul_a       (mul_a),
      .mul_b       (mul_b),
      .itr_n       (itr_n),
      .itr_d       (itr_d),
      .prod        (prod),
      .alu_stat    (alu_stat),
      .quot        (quot),
      .rem         (rem)
   );
endmodule
`default_nettype wire

>>> hdl/bwbrm_checker.sv
// Port-level checker for the run-measure block, bound to the top level.
`default_nettype none
`include "black_white_black_run_measure_assert.svh"
module bwbrm_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire bwbrm_pkg::req_type  req_data,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire bwbrm_pkg::rsp_type  rsp_data
);
   import bwbrm_pkg::*;

   `BWBRM_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid)
   `BWBRM_ASSERT(a_rsp_held, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
   `BWBRM_ASSERT(a_miss_is_zero, rsp_valid |-> rsp_data.found || rsp_data.run_length == '0)
   `BWBRM_ASSERT(a_write_beat_next, req_valid && !req_stall && req_data.func == FUNC_WRITE |=> rsp_valid && !rsp_data.found)
endmodule

bind black_white_black_run_measure bwbrm_checker u_checker (.*);
`default_nettype wire
